// ===== hdl/aoc_pkg.sv =====
// Shared types and constants of the accelerometer offset calibrator.
package aoc_pkg;

  localparam int RawW     = 16;
  localparam int SampleW  = 14;
  localparam int FracW    = 16;
  localparam int OutW     = 32;
  localparam int SumW     = 32;
  localparam int OneGW    = 15;
  localparam int GainW    = 32;
  localparam int StatusW  = 2;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;
  localparam int RegIdxW  = AddrW - 2;
  localparam int MagW     = 34;
  localparam int MulSteps = 34;
  localparam int DvdW     = 48;
  localparam int QuoW     = 33;
  localparam int StepCntW = 6;

  localparam logic [RegIdxW-1:0] REG_ONE_G    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_GAIN     = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SKIP_CAL = 3'd2;
  localparam logic [RegIdxW-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [RegIdxW-1:0] REG_OFFSET_Y = 3'd4;
  localparam logic [RegIdxW-1:0] REG_OFFSET_Z = 3'd5;

  localparam logic [StatusW-1:0] STATUS_ABSORBED  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_OFFSETS   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_CORRECTED = 2'd2;

  localparam logic [OneGW-1:0] ONE_G_RESET = 15'd4096;
  localparam logic [GainW-1:0] GAIN_RESET  = 32'd10283385;

  typedef struct packed {
    logic [OneGW-1:0]       one_g_counts;
    logic [GainW-1:0]       gain_q32;
    logic                   skip_calibration;
    logic signed [OutW-1:0] stored_offset_x;
    logic signed [OutW-1:0] stored_offset_y;
    logic signed [OutW-1:0] stored_offset_z;
  } cfg_t;

endpackage

// ===== hdl/aoc_if.sv =====
// Sample and result channel interfaces of the accelerometer offset calibrator.
interface aoc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [aoc_pkg::RawW-1:0]     raw_x;
  logic signed [aoc_pkg::RawW-1:0]     raw_y;
  logic signed [aoc_pkg::RawW-1:0]     raw_z;
  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

interface aoc_out_if;
  logic                                valid;
  logic                                ready;
  logic [aoc_pkg::StatusW-1:0]         status;
  logic signed [aoc_pkg::OutW-1:0]     out_x;
  logic signed [aoc_pkg::OutW-1:0]     out_y;
  logic signed [aoc_pkg::OutW-1:0]     out_z;
  modport source (output valid, output status, output out_x, output out_y, output out_z,
                  input ready);
  modport sink (input valid, input status, input out_x, input out_y, input out_z,
                output ready);
endinterface

// ===== hdl/aoc_regs.sv =====
// APB configuration registers of the accelerometer offset calibrator.
module aoc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aoc_pkg::AddrW-1:0]   paddr,
  input  logic [aoc_pkg::DataW-1:0]   pwdata,
  output logic [aoc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output aoc_pkg::cfg_t               cfg
);

  logic                          wr;
  logic [aoc_pkg::RegIdxW-1:0]   idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[aoc_pkg::AddrW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_g_counts     <= aoc_pkg::ONE_G_RESET;
      cfg.gain_q32         <= aoc_pkg::GAIN_RESET;
      cfg.skip_calibration <= 1'b0;
      cfg.stored_offset_x  <= '0;
      cfg.stored_offset_y  <= '0;
      cfg.stored_offset_z  <= '0;
    end else if (wr) begin
      case (idx)
        aoc_pkg::REG_ONE_G:    cfg.one_g_counts     <= pwdata[aoc_pkg::OneGW-1:0];
        aoc_pkg::REG_GAIN:     cfg.gain_q32         <= pwdata;
        aoc_pkg::REG_SKIP_CAL: cfg.skip_calibration <= pwdata[0];
        aoc_pkg::REG_OFFSET_X: cfg.stored_offset_x  <= pwdata;
        aoc_pkg::REG_OFFSET_Y: cfg.stored_offset_y  <= pwdata;
        aoc_pkg::REG_OFFSET_Z: cfg.stored_offset_z  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aoc_pkg::REG_ONE_G:    prdata = aoc_pkg::DataW'(cfg.one_g_counts);
      aoc_pkg::REG_GAIN:     prdata = cfg.gain_q32;
      aoc_pkg::REG_SKIP_CAL: prdata = aoc_pkg::DataW'(cfg.skip_calibration);
      aoc_pkg::REG_OFFSET_X: prdata = cfg.stored_offset_x;
      aoc_pkg::REG_OFFSET_Y: prdata = cfg.stored_offset_y;
      aoc_pkg::REG_OFFSET_Z: prdata = cfg.stored_offset_z;
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== hdl/aoc_div.sv =====
// Bit-serial rounded division of an axis sum by the number of calibration samples summed.
module aoc_div #(
  parameter int DIVISOR = 99
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [aoc_pkg::SumW-1:0] sum,
  output logic                            done,
  output logic signed [aoc_pkg::OutW-1:0] offset
);

  localparam int DivW = $clog2(DIVISOR + 1);
  localparam logic [aoc_pkg::QuoW-1:0] QuoLimit = aoc_pkg::QuoW'(1) << 31;

  logic                               busy;
  logic                               fin;
  logic [aoc_pkg::StepCntW-1:0]       cnt;
  logic                               neg;
  logic [aoc_pkg::DvdW-1:0]           dvd;
  logic [DivW-1:0]                    rem;
  logic [aoc_pkg::QuoW-1:0]           quo;
  logic                               ovf;
  logic [aoc_pkg::SumW-1:0]           mag;
  logic [DivW:0]                      trial;
  logic                               ge;
  logic [aoc_pkg::OutW-1:0]           qmag;

  assign mag   = sum[aoc_pkg::SumW-1] ? aoc_pkg::SumW'(-sum) : aoc_pkg::SumW'(sum);
  assign trial = {rem, dvd[aoc_pkg::DvdW-1]};
  assign ge    = trial >= (DivW + 1)'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == aoc_pkg::StepCntW'(aoc_pkg::DvdW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= sum[aoc_pkg::SumW-1];
      dvd <= {mag, 16'(DIVISOR / 2)};
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      rem <= ge ? DivW'(trial - (DivW + 1)'(DIVISOR)) : trial[DivW-1:0];
      quo <= {quo[aoc_pkg::QuoW-2:0], ge};
      ovf <= ovf | quo[aoc_pkg::QuoW-1];
      dvd <= dvd << 1;
    end
  end

  assign done = fin;
  assign qmag = (ovf || quo > QuoLimit) ? 32'h8000_0000 : quo[aoc_pkg::OutW-1:0];

  always_comb begin
    if (neg) begin
      offset = -$signed(qmag);
    end else if (qmag[aoc_pkg::OutW-1]) begin
      offset = 32'sh7FFF_FFFF;
    end else begin
      offset = $signed(qmag);
    end
  end

endmodule

// ===== hdl/aoc_mul.sv =====
// Bit-serial scaling of a counts value by the gain, rounded and saturated.
module aoc_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [aoc_pkg::MagW-1:0]  value,
  input  logic [aoc_pkg::GainW-1:0]        gain,
  output logic                             done,
  output logic signed [aoc_pkg::OutW-1:0]  result
);

  logic                               busy;
  logic                               fin;
  logic [aoc_pkg::StepCntW-1:0]       cnt;
  logic                               neg;
  logic [aoc_pkg::MagW-1:0]           mag;
  logic [aoc_pkg::GainW-1:0]          acc;
  logic [2:0]                         lowb;
  logic [aoc_pkg::GainW:0]            psum;
  logic [aoc_pkg::MagW:0]             rnd;

  assign psum = {1'b0, acc} + (mag[0] ? {1'b0, gain} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == aoc_pkg::StepCntW'(aoc_pkg::MulSteps - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= value[aoc_pkg::MagW-1];
      mag  <= value[aoc_pkg::MagW-1] ? $unsigned(-value) : $unsigned(value);
      acc  <= '0;
      lowb <= '0;
    end else if (busy) begin
      acc  <= psum[aoc_pkg::GainW:1];
      lowb <= {psum[0], lowb[2:1]};
      mag  <= mag >> 1;
    end
  end

  assign done = fin;
  assign rnd  = {1'b0, acc, lowb[2:1]} + (aoc_pkg::MagW + 1)'(lowb[0]);

  always_comb begin
    if (neg) begin
      if (rnd > (aoc_pkg::MagW + 1)'(33'h0_8000_0000)) begin
        result = 32'sh8000_0000;
      end else begin
        result = -$signed(rnd[aoc_pkg::OutW-1:0]);
      end
    end else if (|rnd[aoc_pkg::MagW:aoc_pkg::OutW-1]) begin
      result = 32'sh7FFF_FFFF;
    end else begin
      result = $signed(rnd[aoc_pkg::OutW-1:0]);
    end
  end

endmodule

// ===== hdl/accel_offset_calibrator_core.sv =====
// Top level of the accelerometer offset calibrator with its sequencer.
//
//   Channel   Direction  Contents
//   samples   in         raw_x, raw_y, raw_z: one accelerometer sample
//   results   out        status, out_x, out_y, out_z: one result per sample
//   APB       in/out     configuration registers at byte address 4*i
//
// A sample absorbed into calibration takes no multiplier or divider pass; a corrected sample
// takes three passes through the 34-step serial multiplier; the sample that ends
// calibration adds a 48-step serial divider pass per axis.
// Reset is synchronous and clears the sums, the offsets and the calibration progress.
// A new sample is taken while a finished result waits in the output register.
module accel_offset_calibrator_core #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aoc_pkg::AddrW-1:0]   paddr,
  input  logic [aoc_pkg::DataW-1:0]   pwdata,
  output logic [aoc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  aoc_in_if.sink                      samples,
  aoc_out_if.source                   results
);

  localparam int Divisor = CAL_SAMPLES - 1;
  localparam int CntW    = $clog2(CAL_SAMPLES + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_GO   = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT = 3'd2;
  localparam logic [2:0] ST_MUL_GO   = 3'd3;
  localparam logic [2:0] ST_MUL_WAIT = 3'd4;
  localparam logic [2:0] ST_FINISH   = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  aoc_pkg::cfg_t cfg;

  logic [2:0]                              state;
  logic [1:0]                              axis;
  logic                                    ending;
  logic                                    use_stored;
  logic                                    calibrated;
  logic [CntW-1:0]                         sample_count;
  logic signed [aoc_pkg::SampleW-1:0]      smp [3];
  logic signed [aoc_pkg::SumW-1:0]         sums [3];
  logic signed [aoc_pkg::OutW-1:0]         learned [3];
  logic signed [aoc_pkg::OutW-1:0]         res [3];
  logic [aoc_pkg::StatusW-1:0]             status_r;
  logic                                    div_go;
  logic signed [aoc_pkg::SumW-1:0]         div_sum;
  logic                                    mul_go;
  logic signed [aoc_pkg::MagW-1:0]         mul_value;
  logic                                    out_valid;
  logic [aoc_pkg::StatusW-1:0]             out_status;
  logic signed [aoc_pkg::OutW-1:0]         out_x;
  logic signed [aoc_pkg::OutW-1:0]         out_y;
  logic signed [aoc_pkg::OutW-1:0]         out_z;

  logic                                    accept;
  logic                                    out_load;
  logic                                    div_done;
  logic signed [aoc_pkg::OutW-1:0]         div_off;
  logic                                    mul_done;
  logic signed [aoc_pkg::OutW-1:0]         mul_res;
  logic signed [aoc_pkg::OutW-1:0]         stored_sel;
  logic signed [aoc_pkg::OutW-1:0]         off_sel;
  logic signed [aoc_pkg::SampleW+aoc_pkg::FracW-1:0] smp_q16;
  logic signed [aoc_pkg::MagW-1:0]         mul_in;
  logic signed [aoc_pkg::SampleW-1:0]      in_x;
  logic signed [aoc_pkg::SampleW-1:0]      in_y;
  logic signed [aoc_pkg::SampleW-1:0]      in_z;

  aoc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aoc_div #(.DIVISOR(Divisor)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_go),
    .sum    (div_sum),
    .done   (div_done),
    .offset (div_off)
  );

  aoc_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_go),
    .value  (mul_value),
    .gain   (cfg.gain_q32),
    .done   (mul_done),
    .result (mul_res)
  );

  assign samples.ready  = (state == ST_IDLE) && !rst;
  assign accept         = samples.valid && samples.ready;
  assign out_load       = (state == ST_FINISH) && (!out_valid || results.ready);

  assign results.valid  = out_valid;
  assign results.status = out_status;
  assign results.out_x  = out_x;
  assign results.out_y  = out_y;
  assign results.out_z  = out_z;

  assign in_x = samples.raw_x[aoc_pkg::RawW-1:2];
  assign in_y = samples.raw_y[aoc_pkg::RawW-1:2];
  assign in_z = samples.raw_z[aoc_pkg::RawW-1:2];

  always_comb begin
    case (axis)
      AXIS_X:  stored_sel = cfg.stored_offset_x;
      AXIS_Y:  stored_sel = cfg.stored_offset_y;
      default: stored_sel = cfg.stored_offset_z;
    endcase
  end

  assign off_sel = use_stored ? stored_sel : learned[axis];
  assign smp_q16 = {smp[axis], {aoc_pkg::FracW{1'b0}}};
  assign mul_in  = ending ? aoc_pkg::MagW'(learned[axis])
                          : aoc_pkg::MagW'(smp_q16) - aoc_pkg::MagW'(off_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      axis         <= AXIS_X;
      ending       <= 1'b0;
      use_stored   <= 1'b0;
      calibrated   <= 1'b0;
      sample_count <= '0;
      div_go       <= 1'b0;
      mul_go       <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sums[i]    <= '0;
        learned[i] <= '0;
      end
    end else begin
      div_go <= 1'b0;
      mul_go <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            smp[0] <= in_x;
            smp[1] <= in_y;
            smp[2] <= in_z;
            axis   <= AXIS_X;
            if (cfg.skip_calibration || calibrated) begin
              ending     <= 1'b0;
              use_stored <= cfg.skip_calibration;
              status_r   <= aoc_pkg::STATUS_CORRECTED;
              state      <= ST_MUL_GO;
            end else if (sample_count == '0) begin
              for (int i = 0; i < 3; i++) begin
                sums[i] <= '0;
                res[i]  <= '0;
              end
              sample_count <= CntW'(1);
              status_r     <= aoc_pkg::STATUS_ABSORBED;
              state        <= ST_FINISH;
            end else if (sample_count < CntW'(CAL_SAMPLES)) begin
              sums[0] <= sums[0] + aoc_pkg::SumW'(in_x);
              sums[1] <= sums[1] + aoc_pkg::SumW'(in_y);
              sums[2] <= sums[2] + aoc_pkg::SumW'(in_z)
                         - aoc_pkg::SumW'(cfg.one_g_counts);
              for (int i = 0; i < 3; i++) begin
                res[i] <= '0;
              end
              sample_count <= sample_count + 1'b1;
              status_r     <= aoc_pkg::STATUS_ABSORBED;
              state        <= ST_FINISH;
            end else begin
              ending   <= 1'b1;
              status_r <= aoc_pkg::STATUS_OFFSETS;
              state    <= ST_DIV_GO;
            end
          end
        end
        ST_DIV_GO: begin
          div_sum <= sums[axis];
          div_go  <= 1'b1;
          state   <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            learned[axis] <= div_off;
            state         <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: begin
          mul_value <= mul_in;
          mul_go    <= 1'b1;
          state     <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            res[axis] <= mul_res;
            if (axis == AXIS_Z) begin
              if (ending) begin
                calibrated <= 1'b1;
              end
              state <= ST_FINISH;
            end else begin
              axis  <= axis + 1'b1;
              state <= ending ? ST_DIV_GO : ST_MUL_GO;
            end
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (out_load) begin
        out_valid  <= 1'b1;
        out_status <= status_r;
        out_x      <= res[0];
        out_y      <= res[1];
        out_z      <= res[2];
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/aoc_checker.sv =====
// Port-level assertions for the accelerometer offset calibrator, bound to its top level.
module aoc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_valid,
  input logic                            s_ready,
  input logic                            r_valid,
  input logic                            r_ready,
  input logic [aoc_pkg::StatusW-1:0]     r_status,
  input logic signed [aoc_pkg::OutW-1:0] r_x,
  input logic signed [aoc_pkg::OutW-1:0] r_y,
  input logic signed [aoc_pkg::OutW-1:0] r_z
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_status) && $stable(r_x)
                            && $stable(r_y) && $stable(r_z))
    else $error("Result changed while stalled.");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ready |=> !s_ready)
    else $error("Sample taken while another item is in progress.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> r_status == aoc_pkg::STATUS_ABSORBED || r_status == aoc_pkg::STATUS_OFFSETS
                || r_status == aoc_pkg::STATUS_CORRECTED)
    else $error("Result carries an undefined status.");

  a_absorbed_zero: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_status == aoc_pkg::STATUS_ABSORBED |-> r_x == 0 && r_y == 0 && r_z == 0)
    else $error("Absorbed sample result is not zero.");

endmodule

bind accel_offset_calibrator_core aoc_checker u_aoc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_valid  (samples.valid),
  .s_ready  (samples.ready),
  .r_valid  (results.valid),
  .r_ready  (results.ready),
  .r_status (results.status),
  .r_x      (results.out_x),
  .r_y      (results.out_y),
  .r_z      (results.out_z)
);
